[hdl/polar_to_cartesian_assert.svh]
// Assertion macros for the polar-to-Cartesian converter.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef POLAR_TO_CARTESIAN_ASSERT_SVH
`define POLAR_TO_CARTESIAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define P2C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define P2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/p2c_pkg.sv]
// Package for the polar-to-Cartesian converter: field widths, CORDIC
// constants and the arctangent table. No dependencies.
package p2c_pkg;

  // Field widths of the input and result items.
  localparam int RADIUS_W = 16;
  localparam int ANGLE_W  = 16;
  localparam int COORD_W  = 17;

  // Number of radius bits used and number of CORDIC rotations.
  localparam int DATA_WIDTH = 16;
  localparam int ITERATIONS = 16;

  // Internal fixed-point formats.
  localparam int TABLE_LEN  = 24;
  localparam int ITER_N     = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam int Z_W        = 32;
  localparam int FRAC_BITS  = 24;
  localparam int GAIN_W     = 32;
  localparam int GAIN_SHIFT = GAIN_W - FRAC_BITS;
  localparam int PROD_W     = RADIUS_W + GAIN_W;
  localparam int XY_W       = PROD_W - GAIN_SHIFT + 4;

  // Reciprocal of the CORDIC gain, scaled by 2^32.
  localparam logic [GAIN_W-1:0] INV_GAIN_Q32 = 32'd2608131496;

  // Arctangent of 2^-i, with 2^31 standing for pi.
  localparam logic [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

[hdl/p2c_if.sv]
// Valid/ready channel interfaces for the polar-to-Cartesian converter.
// Depends on p2c_pkg for the field widths.
interface p2c_in_if;
  logic                             valid;
  logic                             ready;
  logic        [p2c_pkg::RADIUS_W-1:0] radius;
  logic signed [p2c_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output radius, output angle, input ready);
  modport sink   (input valid, input radius, input angle, output ready);
endinterface

interface p2c_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [p2c_pkg::COORD_W-1:0] x_coord;
  logic signed [p2c_pkg::COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

[hdl/polar_to_cartesian.sv]
// Polar-to-Cartesian converter: a pipelined CORDIC rotation.
// Depends on p2c_pkg, the channel interfaces in p2c_if.sv and the
// assertion macros in polar_to_cartesian_assert.svh.
//
// Usage:
//   in_ch carries one item per handshake: an unsigned radius and a binary
//   angle (32768 = pi). out_ch returns one item per input item, in order:
//   x_coord = floor(radius*cos(angle)) and y_coord = floor(radius*sin(angle)),
//   saturated to +-(2^16 - 1).
//   The pipeline holds ITER_N + 3 stages: one gain multiply, one quadrant
//   fold, one stage per CORDIC rotation and one output stage that rounds
//   down and saturates. With out_ch ready, one item is taken every cycle.
//   Each stage has its own valid bit and moves on when the stage ahead is
//   empty or moving, so a stalled receiver first fills the empty stages;
//   in_ch.ready falls only when every stage holds an item. Nothing is lost
//   or repeated across a stall.
//   Reset (rst_n low at a clock edge) empties the pipeline; no other state
//   is kept.
module polar_to_cartesian (
  input  logic        clk,
  input  logic        rst_n,
  p2c_in_if.sink      in_ch,
  p2c_out_if.source   out_ch
);
  import p2c_pkg::*;

  `include "polar_to_cartesian_assert.svh"

  // Stage 0 multiplies, stage 1 folds, stages 2..ITER_N+1 rotate, last outputs.
  localparam int NSTG = ITER_N + 3;
  localparam int OSTG = NSTG - 1;

  localparam logic [RADIUS_W-1:0] R_MASK = (DATA_WIDTH >= RADIUS_W) ? '1 :
    RADIUS_W'((64'd1 << DATA_WIDTH) - 64'd1);
  localparam logic signed [XY_W-1:0] LIM = XY_W'((64'd1 << DATA_WIDTH) - 64'd1);

  // The most negative result code, which saturation never produces.
  localparam logic [COORD_W-1:0] MIN_CODE = {1'b1, {(COORD_W-1){1'b0}}};

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   adv;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_r;
  logic              fold_r;
  logic [Z_W-1:0]    z0_r;

  logic signed [XY_W-1:0] cx_r [ITER_N+1];
  logic signed [XY_W-1:0] cy_r [ITER_N+1];
  logic        [Z_W-1:0]  cz_r [ITER_N+1];

  logic signed [XY_W-1:0]    xf;
  logic signed [XY_W-1:0]    yf;
  logic signed [COORD_W-1:0] x_out_r;
  logic signed [COORD_W-1:0] y_out_r;

  // Clamp a value to +-LIM and cut it to the result width.
  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] c;
    c = v;
    if (v > LIM) begin
      c = LIM;
    end else if (v < -LIM) begin
      c = -LIM;
    end
    return c[COORD_W-1:0];
  endfunction

  // A stage moves on when it is empty or the stage ahead moves on.
  assign adv[NSTG] = out_ch.ready;
  for (genvar s = 0; s < NSTG; s++) begin : g_adv
    assign adv[s] = ~v_r[s] | adv[s+1];
  end

  assign in_ch.ready = adv[0];

  // Valid bits shift forward with their items.
  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_ch.valid;
    end
    for (int s = 1; s < NSTG; s++) begin
      if (adv[s]) begin
        v_nxt[s] = v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: scale the radius by the reciprocal gain.
  assign prod = PROD_W'(in_ch.radius & R_MASK) * PROD_W'(INV_GAIN_Q32);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_r <= prod;
      fold_r <= (in_ch.angle[ANGLE_W-1] != in_ch.angle[ANGLE_W-2]);
      z0_r   <= {in_ch.angle, {(Z_W-ANGLE_W){1'b0}}};
    end
  end

  // Stage 1: fold the outer quadrants by negating x and adding pi.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      if (fold_r) begin
        cx_r[0] <= -$signed(XY_W'(prod_r[PROD_W-1:GAIN_SHIFT]));
        cz_r[0] <= z0_r ^ {1'b1, {(Z_W-1){1'b0}}};
      end else begin
        cx_r[0] <= $signed(XY_W'(prod_r[PROD_W-1:GAIN_SHIFT]));
        cz_r[0] <= z0_r;
      end
      cy_r[0] <= '0;
    end
  end

  // One micro-rotation per stage, steered by the sign of the residual angle.
  for (genvar k = 1; k <= ITER_N; k++) begin : g_rot
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    assign dx = cy_r[k-1] >>> (k - 1);
    assign dy = cx_r[k-1] >>> (k - 1);

    always_ff @(posedge clk) begin
      if (adv[k+1]) begin
        if (!cz_r[k-1][Z_W-1]) begin
          cx_r[k] <= cx_r[k-1] - dx;
          cy_r[k] <= cy_r[k-1] + dy;
          cz_r[k] <= cz_r[k-1] - ATAN_TAB[k-1];
        end else begin
          cx_r[k] <= cx_r[k-1] + dx;
          cy_r[k] <= cy_r[k-1] - dy;
          cz_r[k] <= cz_r[k-1] + ATAN_TAB[k-1];
        end
      end
    end
  end

  // Output stage: drop the fraction bits with floor, then saturate.
  assign xf = cx_r[ITER_N] >>> FRAC_BITS;
  assign yf = cy_r[ITER_N] >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv[OSTG]) begin
      x_out_r <= sat_coord(xf);
      y_out_r <= sat_coord(yf);
    end
  end

  assign out_ch.valid   = v_r[OSTG];
  assign out_ch.x_coord = x_out_r;
  assign out_ch.y_coord = y_out_r;

  // The input side stalls only when every stage holds an item.
  `P2C_ASSERT_NOW(a_full_on_stall, !adv[0], (&v_r) && !out_ch.ready,
    "input stalled while the pipeline has an empty stage")

  // A blocked item in the first stage stays there.
  `P2C_ASSERT_NEXT(a_hold_blocked, v_r[0] && !adv[1], v_r[0],
    "item in the multiply stage lost while blocked")

  // Saturation never lets the most negative code through.
  `P2C_ASSERT_NOW(a_sat_x, out_ch.valid, out_ch.x_coord != MIN_CODE,
    "x result outside the saturation range")

  `P2C_ASSERT_NOW(a_sat_y, out_ch.valid, out_ch.y_coord != MIN_CODE,
    "y result outside the saturation range")

endmodule

[dv/tb_polar_to_cartesian.sv]
// Testbench for polar_to_cartesian: random and directed polar items, each
// result checked against a bit-exact CORDIC predictor held in a scoreboard.
// Depends on p2c_pkg, the channel interfaces in p2c_if.sv and the RTL.
`timescale 1ns / 100ps

module tb_polar_to_cartesian;

  localparam int COORD_W   = p2c_pkg::COORD_W;
  localparam int ROT_STEPS = 16;
  localparam int FRAC_W    = 24;
  localparam int GAIN_SHR  = 8;
  localparam longint unsigned INV_GAIN = 64'd2608131496;
  localparam longint COORD_MAX = 65535;
  localparam int HOLD_LEN  = 80;
  localparam int IDLE_PCT  = 37;
  localparam int RAND_ITEMS = 500;

  // Arctangent of 2^-i with 2^31 standing for pi.
  localparam logic [31:0] ARCTAN [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } coord_t;

  // Holds the coordinates still owed by the block, oldest first.
  class coord_scoreboard;
    coord_t      owed_q[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Clamps a rotated value to the symmetric output range.
    function logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < -COORD_MAX) v = -COORD_MAX;
      return v[COORD_W-1:0];
    endfunction

    // Folds the angle into the right half plane, then rotates the
    // gain-scaled radius with the CORDIC micro-rotations.
    function coord_t rotate_to_cartesian(logic [15:0] radius, logic signed [15:0] angle);
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      logic [31:0] phase;
      coord_t      res;
      x = longint'((64'(radius) * INV_GAIN) >> GAIN_SHR);
      y = 0;
      phase = {angle, 16'h0000};
      if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) begin
        x = -x;
        phase = phase + 32'h8000_0000;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (!phase[31]) begin
          x = x - dx;
          y = y + dy;
          phase = phase - ARCTAN[i];
        end else begin
          x = x + dx;
          y = y - dy;
          phase = phase + ARCTAN[i];
        end
      end
      res.x_coord = clamp_coord(x >>> FRAC_W);
      res.y_coord = clamp_coord(y >>> FRAC_W);
      return res;
    endfunction

    function void note_input(logic [15:0] radius, logic signed [15:0] angle);
      owed_q.push_back(rotate_to_cartesian(radius, angle));
    endfunction

    function void check_result(logic signed [COORD_W-1:0] x_got,
                               logic signed [COORD_W-1:0] y_got);
      coord_t want;
      if (owed_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: result x=%0d y=%0d arrived with nothing outstanding",
                   x_got, y_got);
        return;
      end
      want = owed_q.pop_front();
      if (want.x_coord !== x_got || want.y_coord !== y_got) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: expected x=%0d y=%0d, got x=%0d y=%0d",
                   want.x_coord, want.y_coord, x_got, y_got);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_req;
  logic rx_steady;
  bit   tx_steady;

  p2c_in_if  in_ch ();
  p2c_out_if out_ch ();

  coord_scoreboard board = new();

  polar_to_cartesian uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offers one item, idling at random first unless tx_steady is set, and waits until it is taken.
  task automatic offer_item(input logic [15:0] radius, input logic signed [15:0] angle);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.radius <= radius;
    in_ch.angle  <= angle;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(radius, angle);
  endtask

  // Picks a radius that often sits at an extreme.
  function automatic logic [15:0] pick_radius();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'hFFFF;
    if (roll < 20) return 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  // Picks an angle, sometimes close to a quadrant boundary.
  function automatic logic signed [15:0] pick_angle();
    logic [15:0] base;
    if ($urandom_range(99) < 15) begin
      base = 16'($urandom_range(3)) << 14;
      return base + 16'($urandom_range(4)) - 16'd2;
    end
    return 16'($urandom);
  endfunction

  // Result side: checks accepted items and drives ready, with one long
  // hold-off on request and a steady stretch.
  initial begin
    int hold_cnt;
    bit hold_seen;
    out_ch.ready = 1'b0;
    hold_cnt  = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result(out_ch.x_coord, out_ch.y_coord);
      if (hold_req && !hold_seen) begin
        hold_seen = 1;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus: reset, directed corners, then random items.
  initial begin
    logic [15:0]        dir_radius [22];
    logic signed [15:0] dir_angle  [22];
    int                 waited;
    dir_radius = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd32768, 16'd43690,
                   16'd21845, 16'd65534, 16'd12345};
    dir_angle  = '{16'sd0, 16'sd16384, -16'sd32768, -16'sd16384, 16'sd32767,
                   16'sd16383, -16'sd16385, -16'sd16383, 16'sd8192, -16'sd8192,
                   16'sd24576, -16'sd24576, 16'sd12345, -16'sd1, 16'sd8192,
                   -16'sd32768, 16'sd16384, 16'sd4096, -16'sd12000, 16'sd30000,
                   -16'sd1, 16'sd1};
    rst_n        <= 1'b0;
    hold_req     <= 1'b0;
    rx_steady    <= 1'b0;
    tx_steady    = 0;
    in_ch.valid  <= 1'b0;
    in_ch.radius <= '0;
    in_ch.angle  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_radius[i])
      offer_item(dir_radius[i], dir_angle[i]);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      // Stall the result side long enough to fill the whole pipeline.
      if (k == 120) hold_req <= 1'b1;
      if (k == 250) begin
        tx_steady = 1;
        rx_steady <= 1'b1;
      end
      if (k == 350) begin
        tx_steady = 0;
        rx_steady <= 1'b0;
      end
      offer_item(pick_radius(), pick_angle());
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (board.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
